FILE: sv/isg_pkg.sv
// isg_pkg: shared constants, codes and types of the ising metropolis spin update block
// no dependencies; used by every other file of the block by scoped names

package isg_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int SIDE_W     = $clog2(MAX_SIDE);  // row and column index bits
    localparam int SIDEV_W    = 7;                 // lattice_side register width
    localparam int NUM_TABLES = 5;
    localparam int TI_W       = $clog2(NUM_TABLES);
    localparam int RND_W      = 32;
    localparam int THR_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TAB0 = CFG_IDX_W'(1);

    // input command codes carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FLIP = 1'b1;

    typedef logic [THR_W-1:0] thr_row_t;
    typedef thr_row_t thr_tab_t [NUM_TABLES];

    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_FLIP = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SIDE_W-1:0]  row;
        logic [SIDE_W-1:0]  col;
        logic [SIDE_W-1:0]  rp;
        logic [SIDE_W-1:0]  rm;
        logic [SIDE_W-1:0]  cp;
        logic [SIDE_W-1:0]  cm;
        logic               spin_value;
        logic [RND_W-1:0]   rnd;
    } item_t;

    typedef struct packed {
        logic accepted;
        logic spin_now;
    } result_t;

endpackage

FILE: sv/ising_metropolis_spin_update.sv
// ising_metropolis_spin_update: top level with the configuration registers and the
// front stage, item queue and update engine; depends on isg_pkg, isg_front, isg_queue, isg_back
// the engine takes one item at a time from the queue, through the single port spin memory
// (three row reads per flip and a write-back only when the flip is accepted), while the
// front stage and queue keep taking new items
// reset: lattice_side 64, all thresholds all ones, every spin minus one via per-row flags, no sweep

module ising_metropolis_spin_update
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [isg_pkg::S_DATA_W-1:0]        s_tdata,    // row[5:0], col[11:6], spin_value[12],
                                                            // random_fraction[44:13], zero[47:45]
    input  logic                                s_tuser,    // cmd: 0 load, 1 flip
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [isg_pkg::M_DATA_W-1:0]        m_tdata,    // accepted[0], spin_now[1], zero[7:2]
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [isg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isg_pkg::THR_W-1:0]           cfg_data
);

    logic [isg_pkg::SIDEV_W-1:0]    side_reg;
    isg_pkg::thr_tab_t              thr_tab_reg;
    logic                           cfg_xfer;
    logic                           f_push_valid;
    logic                           q_push_ready;
    isg_pkg::item_t                 f_push_item;
    logic                           q_head_valid;
    isg_pkg::item_t                 q_head_item;
    logic                           b_pop;
    logic [isg_pkg::CFG_IDX_W-1:0]  tab_sel;

    // configuration is always taken; indexes past the last table are dropped
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign tab_sel   = cfg_index - isg_pkg::CFG_TAB0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= isg_pkg::SIDEV_W'(isg_pkg::MAX_SIDE);
            for (int i = 0; i < isg_pkg::NUM_TABLES; i++)
            begin
                thr_tab_reg[i] <= '1;
            end
        end
        else if (cfg_xfer)
        begin
            if (cfg_index == isg_pkg::CFG_SIDE)
            begin
                side_reg <= cfg_data[isg_pkg::SIDEV_W-1:0];
            end
            else if ((cfg_index >= isg_pkg::CFG_TAB0) &&
                     (tab_sel < isg_pkg::CFG_IDX_W'(isg_pkg::NUM_TABLES)))
            begin
                thr_tab_reg[tab_sel[isg_pkg::TI_W-1:0]] <= cfg_data;
            end
        end
    end

    // front: takes input transfers, clamps the side, flags out of range sites
    isg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .side       (side_reg),
        .push_valid (f_push_valid),
        .push_ready (q_push_ready),
        .push_item  (f_push_item)
    );

    // two entry queue so the front keeps taking items while the engine works
    isg_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_push_valid),
        .push_ready (q_push_ready),
        .push_item  (f_push_item),
        .head_valid (q_head_valid),
        .pop        (b_pop),
        .head_item  (q_head_item)
    );

    // engine: row reads, metropolis test, write-back and result register
    isg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_item  (q_head_item),
        .pop        (b_pop),
        .thr_tab    (thr_tab_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: sv/isg_front.sv
// isg_front: input stage that takes transfers, checks the site and works out wrapped neighbours
// depends on isg_pkg

module isg_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [isg_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tuser,
    input  logic [isg_pkg::SIDEV_W-1:0]     side,
    output logic                            push_valid,
    input  logic                            push_ready,
    output isg_pkg::item_t                  push_item
);

    logic                           f_valid_reg;
    logic                           f_valid_next;
    isg_pkg::item_t                 f_item_reg;
    isg_pkg::item_t                 f_item_next;
    logic [isg_pkg::SIDEV_W-1:0]    eff;
    logic [isg_pkg::SIDE_W-1:0]     row;
    logic [isg_pkg::SIDE_W-1:0]     col;
    logic [isg_pkg::SIDEV_W-1:0]    row_inc;
    logic [isg_pkg::SIDEV_W-1:0]    col_inc;
    logic [isg_pkg::SIDE_W-1:0]     eff_dec;
    logic                           take;

    assign row = s_tdata[isg_pkg::SIDE_W-1:0];
    assign col = s_tdata[2*isg_pkg::SIDE_W-1:isg_pkg::SIDE_W];

    // clamp side into 2..MAX_SIDE
    always_comb
    begin
        priority if (side < isg_pkg::SIDEV_W'(2))
        begin
            eff = isg_pkg::SIDEV_W'(2);
        end
        else if (side > isg_pkg::SIDEV_W'(isg_pkg::MAX_SIDE))
        begin
            eff = isg_pkg::SIDEV_W'(isg_pkg::MAX_SIDE);
        end
        else
        begin
            eff = side;
        end
    end

    assign row_inc = {1'b0, row} + isg_pkg::SIDEV_W'(1);
    assign col_inc = {1'b0, col} + isg_pkg::SIDEV_W'(1);
    assign eff_dec = isg_pkg::SIDE_W'(eff - isg_pkg::SIDEV_W'(1));

    always_comb
    begin
        f_item_next            = '0;
        f_item_next.row        = row;
        f_item_next.col        = col;
        f_item_next.spin_value = s_tdata[2*isg_pkg::SIDE_W];
        f_item_next.rnd        = s_tdata[2*isg_pkg::SIDE_W+isg_pkg::RND_W:2*isg_pkg::SIDE_W+1];
        f_item_next.rp = (row_inc == eff) ? '0 : row_inc[isg_pkg::SIDE_W-1:0];
        f_item_next.cp = (col_inc == eff) ? '0 : col_inc[isg_pkg::SIDE_W-1:0];
        f_item_next.rm = (row == '0) ? eff_dec : row - isg_pkg::SIDE_W'(1);
        f_item_next.cm = (col == '0) ? eff_dec : col - isg_pkg::SIDE_W'(1);
        priority if (({1'b0, row} >= eff) || ({1'b0, col} >= eff))
        begin
            f_item_next.kind = isg_pkg::KIND_SKIP;
        end
        else if (s_tuser == isg_pkg::CMD_FLIP)
        begin
            f_item_next.kind = isg_pkg::KIND_FLIP;
        end
        else
        begin
            f_item_next.kind = isg_pkg::KIND_LOAD;
        end
    end

    assign s_tready   = !f_valid_reg || push_ready;
    assign take       = s_tvalid && s_tready;
    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (take)
        begin
            f_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

FILE: sv/isg_queue.sv
// isg_queue: short fifo of classified items between the front stage and the update engine
// depends on isg_pkg

module isg_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  isg_pkg::item_t  push_item,
    output logic            head_valid,
    input  logic            pop,
    output isg_pkg::item_t  head_item
);

    isg_pkg::item_t                 slot_reg [isg_pkg::QDEPTH];
    logic [isg_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [isg_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [isg_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [isg_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [isg_pkg::QCNT_W-1:0]     count_reg;
    logic [isg_pkg::QCNT_W-1:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg < isg_pkg::QCNT_W'(isg_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == isg_pkg::QPTR_W'(isg_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + isg_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == isg_pkg::QPTR_W'(isg_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + isg_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + isg_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - isg_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/isg_back.sv
// isg_back: update engine with the row-wide spin memory, neighbour reads, threshold test and output register
// depends on isg_pkg

module isg_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  isg_pkg::item_t                  head_item,
    output logic                            pop,
    input  isg_pkg::thr_tab_t               thr_tab,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [isg_pkg::M_DATA_W-1:0]    m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MID  = 5'b00010,
        ST_UP   = 5'b00100,
        ST_DN   = 5'b01000,
        ST_WB   = 5'b10000
    } state_t;

    typedef logic [isg_pkg::MAX_SIDE-1:0] row_t;

    state_t                         state_reg;
    state_t                         state_next;
    row_t                           mem [isg_pkg::MAX_SIDE];
    row_t                           row_vld_reg;
    row_t                           rd_data_reg;
    logic                           rd_ok_reg;
    row_t                           row_rd;
    isg_pkg::item_t                 itm_reg;
    row_t                           mid_reg;
    logic                           up_reg;
    logic                           dn_reg;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    isg_pkg::result_t               res_reg;
    isg_pkg::result_t               res_next;
    logic                           rd_en;
    logic [isg_pkg::SIDE_W-1:0]     rd_addr;
    logic                           wr_en;
    row_t                           wr_row;
    logic                           out_free;
    logic                           s_old;
    logic [isg_pkg::TI_W-1:0]       plus_cnt;
    logic [isg_pkg::TI_W-1:0]       ti;
    logic [isg_pkg::RND_W-1:0]      thr;
    logic                           acc;

    // a row never written reads as all spins minus one
    assign row_rd   = rd_ok_reg ? rd_data_reg : '0;
    assign out_free = !m_valid_reg || m_tready;

    // neighbour count and threshold pick
    always_comb
    begin
        s_old    = mid_reg[itm_reg.col];
        plus_cnt = isg_pkg::TI_W'(up_reg) + isg_pkg::TI_W'(dn_reg)
                 + isg_pkg::TI_W'(mid_reg[itm_reg.cm]) + isg_pkg::TI_W'(mid_reg[itm_reg.cp]);
        ti       = s_old ? plus_cnt : isg_pkg::TI_W'(isg_pkg::NUM_TABLES - 1) - plus_cnt;
        thr      = s_old ? thr_tab[ti][isg_pkg::RND_W-1:0]
                         : thr_tab[ti][isg_pkg::THR_W-1:isg_pkg::RND_W];
        acc      = (itm_reg.rnd <= thr);
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = itm_reg.row;
        wr_en      = 1'b0;
        wr_row     = mid_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop     = 1'b1;
                    rd_addr = head_item.row;
                    rd_en   = (head_item.kind != isg_pkg::KIND_SKIP);
                    state_next = (head_item.kind == isg_pkg::KIND_SKIP) ? ST_WB : ST_MID;
                end
            end
            ST_MID:
            begin
                if (itm_reg.kind == isg_pkg::KIND_FLIP)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = itm_reg.rp;
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_WB;
                end
            end
            ST_UP:
            begin
                rd_en      = 1'b1;
                rd_addr    = itm_reg.rm;
                state_next = ST_DN;
            end
            ST_DN:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    unique case (itm_reg.kind)
                        isg_pkg::KIND_LOAD:
                        begin
                            wr_en                = 1'b1;
                            wr_row[itm_reg.col]  = itm_reg.spin_value;
                            res_next.accepted    = 1'b1;
                            res_next.spin_now    = itm_reg.spin_value;
                        end
                        isg_pkg::KIND_FLIP:
                        begin
                            wr_en                = acc;
                            wr_row[itm_reg.col]  = s_old ^ acc;
                            res_next.accepted    = acc;
                            res_next.spin_now    = s_old ^ acc;
                        end
                        default:
                        begin
                            res_next.accepted    = 1'b0;
                            res_next.spin_now    = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if ((state_reg == ST_WB) && out_free)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            row_vld_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (wr_en)
            begin
                row_vld_reg[itm_reg.row] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    // single port spin memory, one row per lattice row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[itm_reg.row] <= wr_row;
        end
        else if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            itm_reg <= head_item;
        end
        if (state_reg == ST_MID)
        begin
            mid_reg <= row_rd;
        end
        if (state_reg == ST_UP)
        begin
            up_reg <= row_rd[itm_reg.col];
        end
        if (state_reg == ST_DN)
        begin
            dn_reg <= row_rd[itm_reg.col];
        end
        if ((state_reg == ST_WB) && out_free)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(isg_pkg::M_DATA_W - 2){1'b0}}, res_reg.spin_now, res_reg.accepted};

`ifndef ASSERT_OFF
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("spin memory read and write in the same cycle");

    a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) && (itm_reg.kind == isg_pkg::KIND_SKIP) |-> !wr_en)
        else $error("out of range item wrote the spin memory");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) && out_free |=> m_tvalid && (state_reg == ST_IDLE))
        else $error("finished item did not reach the output register");
`endif

endmodule
